[src/i2c_master_byte_engine_assert.svh]
// Assertion macros for the I2C master byte engine.
// Included by the top level; depends on nothing else.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CMBE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("I2C byte engine check failed");
`define I2CMBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("I2C byte engine check failed");
`else
`define I2CMBE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define I2CMBE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/i2cmbe_pkg.sv]
// Shared types and constants of the I2C master byte engine.
// Used by the top level, the front queue and the bus engine.
package i2cmbe_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   typedef enum logic [16:0] {
      PH_IDLE  = 17'b00000000000000001,
      PH_S1    = 17'b00000000000000010,
      PH_S2    = 17'b00000000000000100,
      PH_S3    = 17'b00000000000001000,
      PH_BLOW  = 17'b00000000000010000,
      PH_BHIGH = 17'b00000000000100000,
      PH_ALOW  = 17'b00000000001000000,
      PH_AHIGH = 17'b00000000010000000,
      PH_POLL  = 17'b00000000100000000,
      PH_RLOW  = 17'b00000001000000000,
      PH_RHIGH = 17'b00000010000000000,
      PH_NLOW  = 17'b00000100000000000,
      PH_NHIGH = 17'b00001000000000000,
      PH_NEND  = 17'b00010000000000000,
      PH_P1    = 17'b00100000000000000,
      PH_P2    = 17'b01000000000000000,
      PH_P3    = 17'b10000000000000000
   } phase_type;

   typedef struct packed {
      logic       is_load;
      logic [7:0] tx_byte;
      logic       with_start;
      logic       with_stop;
      logic       is_read;
      logic       sda_in;
   } item_type;

endpackage

[src/i2cmbe_channels.sv]
// Valid/ready channel interfaces for commands and bus results.
// Standalone; payload fields follow the engine's item and result layout.
interface i2cmbe_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] tx_byte;
   logic       with_start;
   logic       with_stop;
   logic       is_read;
   logic       sda_in;

   modport source (output valid, func, tx_byte, with_start, with_stop, is_read, sda_in,
                   input ready);
   modport sink (input valid, func, tx_byte, with_start, with_stop, is_read, sda_in,
                 output ready);
endinterface

interface i2cmbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic       ack_failed;
   logic [7:0] rx_byte;

   modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                   ack_failed, rx_byte, input ready);
   modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                 ack_failed, rx_byte, output ready);
endinterface

[src/i2c_master_byte_engine.sv]
// I2C master byte engine: one result beat for every accepted command or tick beat.
// An accepted beat passes through the queue and then the result register before its result is shown.
// The engine takes one beat per cycle, with one phase update per beat, while the result channel does not stall.
// A queue of QueueDepth beats separates the input side from the engine and result register.
// Synchronous reset empties the queue, idles the bus engine with SCL high and SDA released,
// and sets the acknowledge timeout to 250.
module i2c_master_byte_engine #(
   parameter int unsigned QueueDepth = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   i2cmbe_req_if.sink   req_ch,
   i2cmbe_rsp_if.source rsp_ch
);
   import i2cmbe_pkg::*;

`include "i2c_master_byte_engine_assert.svh"

   item_type q_item;
   logic     q_valid;
   logic     q_pop;
   logic     stop_levels;

   i2cmbe_front #(
      .QueueDepth (QueueDepth)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   i2cmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_item      (q_item),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

   assign stop_levels = rsp_ch.done_res && rsp_ch.sda_drive && rsp_ch.scl_level &&
                        rsp_ch.sda_level;

   `I2CMBE_ASSERT_SAME(a_done_idle, clock, reset, rsp_ch.valid && rsp_ch.done_res, !rsp_ch.busy_res)
   `I2CMBE_ASSERT_SAME(a_fail_done, clock, reset, rsp_ch.valid && rsp_ch.ack_failed, stop_levels)
   `I2CMBE_ASSERT_SAME(a_release_high, clock, reset, rsp_ch.valid && !rsp_ch.sda_drive, rsp_ch.sda_level)
   `I2CMBE_ASSERT_NEXT(a_queue_drain, clock, reset, !req_ch.ready && rsp_ch.ready, rsp_ch.valid)

endmodule

[src/i2cmbe_front.sv]
// Front end: accepts command and tick beats and queues them for the engine.
// Depends on i2cmbe_pkg and the request channel interface.
module i2cmbe_front #(
   parameter int unsigned QueueDepth = i2cmbe_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   i2cmbe_req_if.sink           req_ch,
   output i2cmbe_pkg::item_type q_item,
   output logic                 q_valid,
   input  logic                 q_pop
);
   import i2cmbe_pkg::*;

   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

   item_type        entry_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   item_type        new_item;
   logic            push;

   assign req_ch.ready = (count_ff < CntW'(QueueDepth));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign q_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.is_load    = req_ch.func;
      new_item.tx_byte    = req_ch.tx_byte;
      new_item.with_start = req_ch.with_start;
      new_item.with_stop  = req_ch.with_stop;
      new_item.is_read    = req_ch.is_read;
      new_item.sda_in     = req_ch.sda_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[src/i2cmbe_back.sv]
// Back end: the bus phase engine and the result register.
// Depends on i2cmbe_pkg and the result channel interface.
module i2cmbe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  i2cmbe_pkg::item_type q_item,
   input  logic                 q_valid,
   output logic                 q_pop,
   i2cmbe_rsp_if.source         rsp_ch
);
   import i2cmbe_pkg::*;

   logic [7:0] ack_timeout_ff;
   phase_type  phase_ff, phase_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] poll_ff, poll_in;
   logic       pending_stop_ff, pending_stop_in;
   logic       reading_ff, reading_in;
   logic       scl_ff, scl_in;
   logic       sda_lvl_ff, sda_lvl_in;
   logic       sda_dir_ff, sda_dir_in;
   logic       fail_ff, fail_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       done_ff, done_in;
   logic       failed_ff, failed_in;
   logic       out_free;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop        = q_valid && out_free;
   assign rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      logic [8:0] poll_next;
      logic       end_done;
      poll_next       = {1'b0, poll_ff} + 9'd1;
      end_done        = 1'b0;
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_in        = shift_ff;
      poll_in         = poll_ff;
      pending_stop_in = pending_stop_ff;
      reading_in      = reading_ff;
      scl_in          = scl_ff;
      sda_lvl_in      = sda_lvl_ff;
      sda_dir_in      = sda_dir_ff;
      fail_in         = fail_ff;
      rx_hold_in      = rx_hold_ff;
      done_in         = 1'b0;
      failed_in       = 1'b0;
      if (q_item.is_load) begin
         if (phase_ff == PH_IDLE) begin
            shift_in        = q_item.tx_byte;
            pending_stop_in = q_item.with_stop;
            reading_in      = q_item.is_read;
            bit_count_in    = '0;
            poll_in         = '0;
            fail_in         = 1'b0;
            if (q_item.with_start) begin
               phase_in = PH_S1;
            end else begin
               phase_in = q_item.is_read ? PH_RLOW : PH_BLOW;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_S1: begin
               sda_dir_in = 1'b1;
               sda_lvl_in = 1'b1;
               scl_in     = 1'b1;
               phase_in   = PH_S2;
            end
            PH_S2: begin
               sda_lvl_in = 1'b0;
               phase_in   = PH_S3;
            end
            PH_S3: begin
               scl_in   = 1'b0;
               phase_in = reading_ff ? PH_RLOW : PH_BLOW;
            end
            PH_BLOW: begin
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_lvl_in = shift_ff[7];
               phase_in   = PH_BHIGH;
            end
            PH_BHIGH: begin
               scl_in       = 1'b1;
               shift_in     = {shift_ff[6:0], 1'b0};
               phase_in     = (bit_count_ff == 3'd7) ? PH_ALOW : PH_BLOW;
               bit_count_in = bit_count_ff + 3'd1;
            end
            PH_ALOW: begin
               scl_in     = 1'b0;
               sda_dir_in = 1'b0;
               sda_lvl_in = 1'b1;
               phase_in   = PH_AHIGH;
            end
            PH_AHIGH: begin
               scl_in   = 1'b1;
               poll_in  = '0;
               phase_in = PH_POLL;
            end
            PH_POLL: begin
               if (!q_item.sda_in) begin
                  scl_in   = 1'b0;
                  end_done = 1'b1;
               end else if (poll_next > {1'b0, ack_timeout_ff}) begin
                  fail_in         = 1'b1;
                  pending_stop_in = 1'b1;
                  phase_in        = PH_P1;
               end else begin
                  poll_in = poll_next[7:0];
               end
            end
            PH_RLOW: begin
               scl_in     = 1'b0;
               sda_dir_in = 1'b0;
               sda_lvl_in = 1'b1;
               phase_in   = PH_RHIGH;
            end
            PH_RHIGH: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], q_item.sda_in};
               if (bit_count_ff == 3'd7) begin
                  rx_hold_in = {shift_ff[6:0], q_item.sda_in};
                  phase_in   = PH_NLOW;
               end else begin
                  phase_in = PH_RLOW;
               end
               bit_count_in = bit_count_ff + 3'd1;
            end
            PH_NLOW: begin
               scl_in     = 1'b0;
               sda_dir_in = 1'b1;
               sda_lvl_in = 1'b1;
               phase_in   = PH_NHIGH;
            end
            PH_NHIGH: begin
               scl_in   = 1'b1;
               phase_in = PH_NEND;
            end
            PH_NEND: begin
               scl_in   = 1'b0;
               end_done = 1'b1;
            end
            PH_P1: begin
               sda_dir_in = 1'b1;
               scl_in     = 1'b0;
               sda_lvl_in = 1'b0;
               phase_in   = PH_P2;
            end
            PH_P2: begin
               scl_in   = 1'b1;
               phase_in = PH_P3;
            end
            PH_P3: begin
               sda_lvl_in = 1'b1;
               phase_in   = PH_IDLE;
               done_in    = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         if (end_done) begin
            if (pending_stop_ff) begin
               phase_in = PH_P1;
            end else begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         if (done_in) begin
            failed_in = fail_ff;
            fail_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         ack_timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= '0;
         shift_ff        <= '0;
         poll_ff         <= '0;
         pending_stop_ff <= 1'b0;
         reading_ff      <= 1'b0;
         scl_ff          <= 1'b1;
         sda_lvl_ff      <= 1'b1;
         sda_dir_ff      <= 1'b0;
         fail_ff         <= 1'b0;
         rx_hold_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         done_ff         <= 1'b0;
         failed_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff        <= phase_in;
            bit_count_ff    <= bit_count_in;
            shift_ff        <= shift_in;
            poll_ff         <= poll_in;
            pending_stop_ff <= pending_stop_in;
            reading_ff      <= reading_in;
            scl_ff          <= scl_in;
            sda_lvl_ff      <= sda_lvl_in;
            sda_dir_ff      <= sda_dir_in;
            fail_ff         <= fail_in;
            rx_hold_ff      <= rx_hold_in;
            done_ff         <= done_in;
            failed_ff       <= failed_in;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.scl_level  = scl_ff;
   assign rsp_ch.sda_level  = sda_lvl_ff;
   assign rsp_ch.sda_drive  = sda_dir_ff;
   assign rsp_ch.busy_res   = (phase_ff != PH_IDLE);
   assign rsp_ch.done_res   = done_ff;
   assign rsp_ch.ack_failed = failed_ff;
   assign rsp_ch.rx_byte    = rx_hold_ff;

endmodule
